FILE: src/kgat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kgat_pkg;

  // Item kinds carried in the func field
  localparam logic [1:0] FUNC_FULL = 2'd0;
  localparam logic [1:0] FUNC_HALF = 2'd1;
  localparam logic [1:0] FUNC_HOME = 2'd2;

  // Glyph layouts
  localparam logic [1:0] MODE_JIS     = 2'd0;
  localparam logic [1:0] MODE_HANGUL  = 2'd1;
  localparam logic [1:0] MODE_GAMEBOX = 2'd2;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_CODE = 3'd7;

  // JIS range bounds
  localparam logic [7:0]  JIS_LEAD_LO   = 8'h81;
  localparam logic [7:0]  JIS_LEAD_HI   = 8'h9F;
  localparam logic [7:0]  JIS_LEAD_E0   = 8'hE0;
  localparam logic [7:0]  JIS_LEAD_E0_SUB = 8'hC1;
  localparam logic [7:0]  JIS_TRAIL_LO  = 8'h40;
  localparam logic [7:0]  JIS_TRAIL_MID_HI = 8'h7F;
  localparam logic [7:0]  JIS_TRAIL_80  = 8'h80;
  localparam logic [7:0]  JIS_TRAIL_HI  = 8'hFC;
  localparam logic [7:0]  JIS_TRAIL_SUB = 8'h41;
  localparam logic [15:0] JIS_ROW_LEN   = 16'h00BC;
  localparam logic [15:0] GLYPH_BASE_JIS = 16'h0070;

  // Table layouts
  localparam logic [15:0] CODE_BASE       = 16'h8140;
  localparam logic [7:0]  HANGUL_HI_GAP   = 8'd7;
  localparam logic [7:0]  HANGUL_HI_SKIP  = 8'd3;
  localparam logic [7:0]  HANGUL_ROW_LEN  = 8'hBD;
  localparam logic [15:0] HANGUL_ENTRIES  = 16'd4713;
  localparam logic [15:0] GLYPH_BASE_TBL  = 16'h0080;
  localparam logic [15:0] GAMEBOX_ROW_LEN = 16'h00BB;
  localparam logic [15:0] GB_GAP0_AT      = 16'h0DE1;
  localparam logic [15:0] GB_GAP0_LEN     = 16'h01CD;
  localparam logic [15:0] GB_GAP1_AT      = 16'h0BB0;
  localparam logic [15:0] GB_GAP1_LEN     = 16'h012C;
  localparam logic [15:0] GB_GAP2_AT      = 16'h02EC;
  localparam logic [15:0] GB_GAP2_LEN     = 16'h0118;
  localparam logic [7:0]  GB_LO_SKIP      = 8'h3F;
  localparam logic [7:0]  GB_LO_SPLIT     = 8'h1C;
  localparam logic [15:0] GB_BASE_LOW     = 16'h007F;

  // Space-narrowing codes and the row that exempts some of them
  localparam logic [7:0]  SPACE_LEAD_HANGUL  = 8'h81;
  localparam logic [7:0]  SPACE_LEAD_GAMEBOX = 8'h91;
  localparam logic [7:0]  SPACE_TRAIL_A      = 8'h40;
  localparam logic [7:0]  SPACE_TRAIL_B      = 8'h41;
  localparam logic [15:0] EXEMPT_ROW         = 16'd295;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] lead_byte;
    logic [7:0] trail_byte;
  } in_item_t;

  typedef struct packed {
    logic        draw;
    logic [23:0] glyph_offset;
    logic [18:0] pixel_x;
    logic [15:0] pixel_y;
    logic        half_width;
    logic        out_of_range;
    logic        line_broken;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  font_mode;
    logic [7:0]  char_width;
    logic [7:0]  line_height;
    logic [15:0] window_left;
    logic [15:0] window_top;
    logic [15:0] right_limit;
    logic [15:0] bottom_limit;
    logic [15:0] newline_code;
  } cfg_t;

  // Glyph lookup result handed to the cursor and result logic
  typedef struct packed {
    logic [23:0] offset;
    logic        oor;
    logic        narrow;
    logic        newline;
  } glyph_t;

  // Cursor status: position held before the current item and line-break flag
  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic        line_broken;
  } cur_t;

endpackage

`default_nettype wire

FILE: src/kgat_glyph_map.sv
`timescale 1ns / 1ps
`default_nettype none

module kgat_glyph_map #(
  parameter int FULL_GLYPH_BYTES = 32,
  parameter int HALF_GLYPH_BYTES = 16,
  parameter int FONT_STORE_BYTES = 262144
) (
  input  kgat_pkg::in_item_t item_i,
  input  kgat_pkg::cfg_t     cfg_i,
  input  logic [15:0]        row_i,
  output kgat_pkg::glyph_t   glyph_o
);

  logic [7:0]  lead;
  logic [7:0]  trail;
  logic [7:0]  jis_lead;
  logic [7:0]  jis_trail;
  logic [15:0] jis_idx;
  logic [15:0] code;
  logic [7:0]  hi_raw;
  logic [7:0]  hi_hg;
  logic [7:0]  lo_raw;
  logic [15:0] hg_prod;
  logic [15:0] hg_idx;
  logic [15:0] gb_idx;
  logic [7:0]  gb_lo;
  logic [15:0] full_idx;
  logic [23:0] offset;
  logic        narrow;

  assign lead  = item_i.lead_byte;
  assign trail = item_i.trail_byte;

  // JIS: bytes outside their ranges pass through unchanged
  always_comb begin
    if (lead >= kgat_pkg::JIS_LEAD_LO && lead <= kgat_pkg::JIS_LEAD_HI) begin
      jis_lead = lead - kgat_pkg::JIS_LEAD_LO;
    end else if (lead >= kgat_pkg::JIS_LEAD_E0) begin
      jis_lead = lead - kgat_pkg::JIS_LEAD_E0_SUB;
    end else begin
      jis_lead = lead;
    end
    if (trail >= kgat_pkg::JIS_TRAIL_LO && trail <= kgat_pkg::JIS_TRAIL_MID_HI) begin
      jis_trail = trail - kgat_pkg::JIS_TRAIL_LO;
    end else if (trail >= kgat_pkg::JIS_TRAIL_80 && trail <= kgat_pkg::JIS_TRAIL_HI) begin
      jis_trail = trail - kgat_pkg::JIS_TRAIL_SUB;
    end else begin
      jis_trail = trail;
    end
    jis_idx = {8'd0, jis_lead} * kgat_pkg::JIS_ROW_LEN + {8'd0, jis_trail}
              + kgat_pkg::GLYPH_BASE_JIS;
  end

  assign code   = {lead, trail} - kgat_pkg::CODE_BASE;
  assign hi_raw = code[15:8];
  assign lo_raw = code[7:0];

  // Patched hangul table: rows past the gap close up, short rows only
  always_comb begin
    hi_hg   = (hi_raw >= kgat_pkg::HANGUL_HI_GAP) ? hi_raw - kgat_pkg::HANGUL_HI_SKIP
                                                  : hi_raw;
    hg_prod = {8'd0, hi_hg} * {8'd0, kgat_pkg::HANGUL_ROW_LEN} + {8'd0, lo_raw};
    if (lo_raw < kgat_pkg::HANGUL_ROW_LEN && hg_prod < kgat_pkg::HANGUL_ENTRIES) begin
      hg_idx = hg_prod + kgat_pkg::GLYPH_BASE_TBL;
    end else begin
      hg_idx = kgat_pkg::GLYPH_BASE_TBL;
    end
  end

  // Game-box table: three gaps in the row space, one hole per row
  always_comb begin
    gb_idx = {8'd0, hi_raw} * kgat_pkg::GAMEBOX_ROW_LEN;
    if (gb_idx >= kgat_pkg::GB_GAP0_AT) gb_idx = gb_idx - kgat_pkg::GB_GAP0_LEN;
    if (gb_idx >= kgat_pkg::GB_GAP1_AT) gb_idx = gb_idx - kgat_pkg::GB_GAP1_LEN;
    if (gb_idx >= kgat_pkg::GB_GAP2_AT) gb_idx = gb_idx - kgat_pkg::GB_GAP2_LEN;
    gb_lo  = (lo_raw >= kgat_pkg::GB_LO_SKIP) ? lo_raw - 8'd1 : lo_raw;
    gb_idx = gb_idx + {8'd0, gb_lo};
    gb_idx = gb_idx + ((gb_lo >= kgat_pkg::GB_LO_SPLIT) ? kgat_pkg::GB_BASE_LOW
                                                        : kgat_pkg::GLYPH_BASE_TBL);
  end

  always_comb begin
    full_idx = '0;
    narrow   = 1'b0;
    case (cfg_i.font_mode)
      kgat_pkg::MODE_JIS: begin
        full_idx = jis_idx;
      end
      kgat_pkg::MODE_HANGUL: begin
        full_idx = hg_idx;
        narrow   = lead == kgat_pkg::SPACE_LEAD_HANGUL && trail == kgat_pkg::SPACE_TRAIL_A
                   && row_i != kgat_pkg::EXEMPT_ROW;
      end
      kgat_pkg::MODE_GAMEBOX: begin
        full_idx = gb_idx;
        narrow   = lead == kgat_pkg::SPACE_LEAD_GAMEBOX
                   && (trail == kgat_pkg::SPACE_TRAIL_A
                       || (trail == kgat_pkg::SPACE_TRAIL_B
                           && row_i != kgat_pkg::EXEMPT_ROW));
      end
      default: begin
        full_idx = '0;
      end
    endcase
  end

  always_comb begin
    if (item_i.func == kgat_pkg::FUNC_HALF) begin
      offset = {16'd0, lead} * 24'(HALF_GLYPH_BYTES);
    end else begin
      offset = {8'd0, full_idx} * 24'(FULL_GLYPH_BYTES);
    end
  end

  assign glyph_o.offset  = offset;
  assign glyph_o.oor     = {1'b0, offset} >= 25'(FONT_STORE_BYTES);
  assign glyph_o.narrow  = item_i.func == kgat_pkg::FUNC_FULL && narrow;
  assign glyph_o.newline = item_i.func == kgat_pkg::FUNC_FULL
                           && {lead, trail} == cfg_i.newline_code;

endmodule

`default_nettype wire

FILE: src/kgat_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module kgat_cursor #(
  parameter int EDGE_MARGIN = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       func_i,
  input  kgat_pkg::glyph_t glyph_i,
  input  kgat_pkg::cfg_t   cfg_i,
  output kgat_pkg::cur_t   cur_o
);

  logic [15:0]        col_q, col_d;
  logic [15:0]        row_q, row_d;
  logic [15:0]        col_base;
  logic signed [17:0] col_reach;
  logic signed [17:0] row_reach;
  logic               col_wrap;
  logic               row_wrap;
  logic [15:0]        row_brk;
  logic               broken;

  assign col_base  = glyph_i.narrow ? col_q - 16'd1 : col_q;
  assign col_reach = $signed({2'b00, col_base} + {9'd0, cfg_i.char_width, 1'b0}
                             - 18'(EDGE_MARGIN));
  assign col_wrap  = col_reach >= $signed({2'b00, cfg_i.right_limit});
  assign row_reach = $signed({2'b00, row_q} + {9'd0, cfg_i.line_height, 1'b0}
                             - 18'(EDGE_MARGIN));
  assign row_wrap  = row_reach >= $signed({2'b00, cfg_i.bottom_limit});
  assign row_brk   = row_wrap ? cfg_i.window_top : row_q + {8'd0, cfg_i.line_height};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    broken = 1'b0;
    case (func_i)
      kgat_pkg::FUNC_FULL, kgat_pkg::FUNC_HALF: begin
        broken = glyph_i.newline || col_wrap;
        if (broken) begin
          col_d = cfg_i.window_left;
          row_d = row_brk;
        end else begin
          col_d = col_base + {8'd0, cfg_i.char_width};
        end
      end
      kgat_pkg::FUNC_HOME: begin
        col_d = cfg_i.window_left;
        row_d = cfg_i.window_top;
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign cur_o.col         = col_q;
  assign cur_o.row         = row_q;
  assign cur_o.line_broken = broken;

endmodule

`default_nettype wire

FILE: src/kanji_glyph_address_and_text_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

// Kanji glyph addresser and text cursor.
//
// Input channel: one beat per character or command (func, lead_byte,
// trail_byte). Output channel: one beat per input beat, in order, giving
// the glyph offset in the font store and the pixel position of the
// cursor as it stood before the item, plus wrap and range flags.
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is
// high; write only while no item is in flight.
//
// Pipeline: an item passes through the input register, then the result
// register, before its result beat leaves. Throughput: one item per
// cycle while the receiver does not stall; the cursor update is a single
// add-and-compare loop.
//
// Reset clears both valid bits and the cursor (column 0, row 0) and loads
// the default layout registers. When the receiver stalls, the result
// register holds its beat; the input register keeps taking one more beat
// and then raises in_stall_o until the result moves on.
module kanji_glyph_address_and_text_cursor #(
  parameter int FULL_GLYPH_BYTES = 32,
  parameter int HALF_GLYPH_BYTES = 16,
  parameter int FONT_STORE_BYTES = 262144,
  parameter int EDGE_MARGIN      = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  kgat_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output kgat_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [kgat_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                      cfg_data_i
);

  kgat_pkg::cfg_t      cfg_q;
  kgat_pkg::in_item_t  in_q;
  logic                in_valid_q;
  kgat_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;
  logic                step;
  logic                in_take;
  kgat_pkg::glyph_t    glyph;
  kgat_pkg::cur_t      cur;

  // Move the held item into the result register when that register frees up
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_mode    <= kgat_pkg::MODE_JIS;
      cfg_q.char_width   <= 8'd2;
      cfg_q.line_height  <= 8'd16;
      cfg_q.window_left  <= 16'd0;
      cfg_q.window_top   <= 16'd0;
      cfg_q.right_limit  <= 16'd80;
      cfg_q.bottom_limit <= 16'd400;
      cfg_q.newline_code <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kgat_pkg::REG_FONT_MODE:    cfg_q.font_mode    <= cfg_data_i[1:0];
        kgat_pkg::REG_CHAR_WIDTH:   cfg_q.char_width   <= cfg_data_i[7:0];
        kgat_pkg::REG_LINE_HEIGHT:  cfg_q.line_height  <= cfg_data_i[7:0];
        kgat_pkg::REG_WINDOW_LEFT:  cfg_q.window_left  <= cfg_data_i;
        kgat_pkg::REG_WINDOW_TOP:   cfg_q.window_top   <= cfg_data_i;
        kgat_pkg::REG_RIGHT_LIMIT:  cfg_q.right_limit  <= cfg_data_i;
        kgat_pkg::REG_BOTTOM_LIMIT: cfg_q.bottom_limit <= cfg_data_i;
        kgat_pkg::REG_NEWLINE_CODE: cfg_q.newline_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register: valid resets, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  kgat_glyph_map #(
    .FULL_GLYPH_BYTES(FULL_GLYPH_BYTES),
    .HALF_GLYPH_BYTES(HALF_GLYPH_BYTES),
    .FONT_STORE_BYTES(FONT_STORE_BYTES)
  ) u_glyph_map (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .row_i  (cur.row),
    .glyph_o(glyph)
  );

  kgat_cursor #(
    .EDGE_MARGIN(EDGE_MARGIN)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .func_i (in_q.func),
    .glyph_i(glyph),
    .cfg_i  (cfg_q),
    .cur_o  (cur)
  );

  // Assemble the result beat; home and the unused func code report all zeros
  always_comb begin
    out_d = '0;
    case (in_q.func)
      kgat_pkg::FUNC_FULL, kgat_pkg::FUNC_HALF: begin
        out_d.pixel_x     = {cur.col, 3'b000};
        out_d.pixel_y     = cur.row;
        out_d.line_broken = cur.line_broken;
        if (!glyph.newline) begin
          out_d.draw         = !glyph.oor;
          out_d.glyph_offset = glyph.offset;
          out_d.half_width   = in_q.func == kgat_pkg::FUNC_HALF;
          out_d.out_of_range = glyph.oor;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  // Result register: load on step, drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A drawn glyph is never flagged out of range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.draw && out_data_o.out_of_range))
    else $error("draw and out_of_range both set");

  // The cursor only moves when an item passes into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> (cur.col == $past(cur.col)) && (cur.row == $past(cur.row)))
    else $error("cursor moved without an item");

  // A character result reports the row held before the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (in_q.func == kgat_pkg::FUNC_FULL || in_q.func == kgat_pkg::FUNC_HALF))
    |=> out_data_o.pixel_y == $past(cur.row))
    else $error("pixel_y does not match the old cursor row");

endmodule

`default_nettype wire
